[sv/assert_macros.svh]
// Assertion macros for the RTL file that carries checks.
// No dependencies; expects clk and rst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset
`define BSAG_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Checked on every clock edge, reset included
`define BSAG_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

[sv/bsag_pkg.sv]
// Package for the scaler address generator: widths, codes and shared types.
// No dependencies; used by every module of the block.
package bsag_pkg;

  // Geometry limits and derived widths
  localparam int MAX_SRC_DIM = 2048;
  localparam int MAX_DST_DIM = 4096;
  localparam int OFFSET_BITS = 22;
  localparam int SRC_W       = $clog2(MAX_SRC_DIM) + 1;
  localparam int DST_W       = $clog2(MAX_DST_DIM) + 1;
  localparam int POS_W       = OFFSET_BITS + 1;
  localparam int IDX_W       = 24;
  localparam int PROD_W      = 2 * SRC_W;

  // Divider: one quotient bit per step
  localparam int DIV_STEPS   = SRC_W;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

  // Queue between front and back
  localparam int FIFO_DEPTH  = 2;
  localparam int FIFO_PTR_W  = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

  // Configuration port
  localparam int CFG_ADDR_W  = 5;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_IDX_W   = CFG_ADDR_W - 2;

  localparam logic [SRC_W-1:0]       SRC_WIDTH_RST    = SRC_W'(256);
  localparam logic [SRC_W-1:0]       SRC_HEIGHT_RST   = SRC_W'(240);
  localparam logic [DST_W-1:0]       DST_WIDTH_RST    = DST_W'(256);
  localparam logic [DST_W-1:0]       DST_HEIGHT_RST   = DST_W'(240);
  localparam logic [OFFSET_BITS-1:0] START_OFFSET_RST = '0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_WIDTH,
    REG_SRC_HEIGHT,
    REG_DST_WIDTH,
    REG_DST_HEIGHT,
    REG_START_OFFSET
  } cfg_reg_t;

  // Live configuration as seen by the back end
  typedef struct packed {
    logic [SRC_W-1:0]       src_width;
    logic [SRC_W-1:0]       src_height;
    logic [DST_W-1:0]       dst_width;
    logic [DST_W-1:0]       dst_height;
    logic [OFFSET_BITS-1:0] start_offset;
  } cfg_t;

  // Item class decided by the front end
  typedef enum logic {
    KIND_ADVANCE,
    KIND_RESTART
  } item_kind_t;

  typedef struct packed {
    logic       valid;
    item_kind_t kind;
  } q_head_t;

  // Divider request / response
  typedef struct packed {
    logic             start;
    logic [SRC_W-1:0] dividend;
    logic [DST_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [SRC_W-1:0] quot;
    logic [SRC_W-1:0] rem;
  } div_rsp_t;

  // Back-end sequencer
  typedef enum logic [2:0] {
    BE_IDLE,
    BE_DIV_X,
    BE_DIV_Y,
    BE_MUL,
    BE_INIT,
    BE_STEP
  } be_state_t;

endpackage

[sv/bsag_div.sv]
// Iterative restoring divider, one quotient bit per cycle.
// Depends on bsag_pkg (widths, div_req_t, div_rsp_t).
module bsag_div import bsag_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [SRC_W-1:0]     quo_r, quo_nxt;
  logic [DST_W-1:0]     rem_r, rem_nxt;
  logic [DST_W-1:0]     dvs_r, dvs_nxt;
  logic [DST_W:0]       trial;
  logic [DST_W:0]       diff;
  logic                 ge;

  // One trial subtraction per step
  always_comb begin
    trial = {rem_r, quo_r[SRC_W-1]};
    diff  = trial - {1'b0, dvs_r};
    ge    = trial >= {1'b0, dvs_r};
  end

  // Step control: latch operands on start, shift in a bit while busy
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DIV_CNT_W'(DIV_STEPS - 1);
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
    end else if (busy_r) begin
      quo_nxt = {quo_r[SRC_W-2:0], ge};
      rem_nxt = ge ? diff[DST_W-1:0] : trial[DST_W-1:0];
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - DIV_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  // Remainder never exceeds the dividend
  assign rsp.done = done_r;
  assign rsp.quot = quo_r;
  assign rsp.rem  = rem_r[SRC_W-1:0];

endmodule

[sv/bsag_front.sv]
// Front end: takes request words, classifies them and queues them for the back end.
// Depends on bsag_pkg (item_kind_t, q_head_t, queue sizes).
module bsag_front import bsag_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  logic    in_frame_start,
  input  logic    q_pop,
  output q_head_t q_head
);

  item_kind_t            q_kind_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CNT_W-1:0] count_r, count_nxt;
  logic                  push;
  item_kind_t            kind;

  // Classify: an explicit restart or a plain advance
  assign kind     = in_frame_start ? KIND_RESTART : KIND_ADVANCE;
  assign in_ready = count_r != FIFO_CNT_W'(FIFO_DEPTH);
  assign push     = in_valid && in_ready;

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0
                                                             : wr_ptr_r + FIFO_PTR_W'(1);
    end
    if (q_pop) begin
      rd_ptr_nxt = (rd_ptr_r == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0
                                                             : rd_ptr_r + FIFO_PTR_W'(1);
    end
    case ({push, q_pop})
      2'b10:   count_nxt = count_r + FIFO_CNT_W'(1);
      2'b01:   count_nxt = count_r - FIFO_CNT_W'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_kind_r[wr_ptr_r] <= kind;
    end
  end

  assign q_head.valid = count_r != '0;
  assign q_head.kind  = q_kind_r[rd_ptr_r];

endmodule

[sv/bsag_back.sv]
// Back end: frame setup sequencer, Bresenham step datapath and result register.
// Depends on bsag_pkg and bsag_div.
module bsag_back import bsag_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  cfg_t                   cfg,
  input  q_head_t                q_head,
  output logic                   q_pop,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [OFFSET_BITS-1:0] out_source_offset,
  output logic [IDX_W-1:0]       out_dest_index,
  output logic                   out_row_end,
  output logic                   out_frame_end
);

  be_state_t state_r, state_nxt;

  // Frame state
  logic [DST_W-1:0]  col_left_r, col_left_nxt;
  logic [DST_W-1:0]  row_left_r, row_left_nxt;
  logic [DST_W-1:0]  x_error_r, x_error_nxt;
  logic [DST_W-1:0]  y_error_r, y_error_nxt;
  logic [POS_W-1:0]  src_pos_r, src_pos_nxt;
  logic [IDX_W-1:0]  dst_pos_r, dst_pos_nxt;
  logic [SRC_W-1:0]  x_quot_r, x_quot_nxt;
  logic [SRC_W-1:0]  x_rem_r, x_rem_nxt;
  logic [SRC_W-1:0]  y_quot_r, y_quot_nxt;
  logic [SRC_W-1:0]  y_rem_r, y_rem_nxt;
  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic [POS_W-1:0]  y_row_step_r, y_row_step_nxt;

  // Result register
  logic                   out_valid_r, out_valid_nxt;
  logic [OFFSET_BITS-1:0] out_offset_r, out_offset_nxt;
  logic [IDX_W-1:0]       out_index_r, out_index_nxt;
  logic                   out_rend_r, out_rend_nxt;
  logic                   out_fend_r, out_fend_nxt;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic             out_free;
  logic             restart;
  logic             step_en;
  logic [DST_W-1:0] dw;
  logic [DST_W-1:0] dh;

  // Step datapath terms
  logic [DST_W:0]   x_sum, y_sum;
  logic             x_carry, y_carry;
  logic [DST_W:0]   x_err_wrap, y_err_wrap;
  logic [POS_W-1:0] pos_col, pos_row;
  logic             row_end, frame_end;

  bsag_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // A zero destination size counts as one
  assign dw = (cfg.dst_width  == '0) ? DST_W'(1) : cfg.dst_width;
  assign dh = (cfg.dst_height == '0) ? DST_W'(1) : cfg.dst_height;

  assign out_free = !out_valid_r || out_ready;
  // A finished or never-started frame restarts on any item
  assign restart  = (q_head.kind == KIND_RESTART) || (row_left_r == '0) || (col_left_r == '0);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BE_IDLE:  if (q_head.valid && restart) state_nxt = BE_DIV_X;
      BE_DIV_X: if (div_rsp.done) state_nxt = BE_DIV_Y;
      BE_DIV_Y: if (div_rsp.done) state_nxt = BE_MUL;
      BE_MUL:   state_nxt = BE_INIT;
      BE_INIT:  state_nxt = BE_STEP;
      BE_STEP:  if (out_free) state_nxt = BE_IDLE;
      default:  state_nxt = BE_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    step_en          = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = cfg.src_width;
    div_req.divisor  = dw;
    unique case (state_r)
      BE_IDLE: begin
        div_req.start = q_head.valid && restart;
        step_en       = q_head.valid && !restart && out_free;
      end
      BE_DIV_X: begin
        div_req.start    = div_rsp.done;
        div_req.dividend = cfg.src_height;
        div_req.divisor  = dh;
      end
      BE_STEP:  step_en = out_free;
      default:  step_en = 1'b0;
    endcase
  end

  assign q_pop = step_en;

  // Bresenham step: column advance, then row carry on the last pixel
  always_comb begin
    x_sum      = {1'b0, x_error_r} + (DST_W + 1)'(x_rem_r);
    x_carry    = x_sum >= {1'b0, dw};
    x_err_wrap = x_carry ? x_sum - {1'b0, dw} : x_sum;
    pos_col    = src_pos_r + POS_W'(x_quot_r) + POS_W'(x_carry);

    y_sum      = {1'b0, y_error_r} + (DST_W + 1)'(y_rem_r);
    y_carry    = y_sum >= {1'b0, dh};
    y_err_wrap = y_carry ? y_sum - {1'b0, dh} : y_sum;
    pos_row    = pos_col + y_row_step_r + (y_carry ? POS_W'(cfg.src_width) : '0);

    row_end    = col_left_r == DST_W'(1);
    frame_end  = row_end && (row_left_r == DST_W'(1));
  end

  // Frame state updates: setup captures, init, per-pixel step
  always_comb begin
    col_left_nxt   = col_left_r;
    row_left_nxt   = row_left_r;
    x_error_nxt    = x_error_r;
    y_error_nxt    = y_error_r;
    src_pos_nxt    = src_pos_r;
    dst_pos_nxt    = dst_pos_r;
    x_quot_nxt     = x_quot_r;
    x_rem_nxt      = x_rem_r;
    y_quot_nxt     = y_quot_r;
    y_rem_nxt      = y_rem_r;
    prod_nxt       = prod_r;
    y_row_step_nxt = y_row_step_r;

    if (state_r == BE_DIV_X && div_rsp.done) begin
      x_quot_nxt = div_rsp.quot;
      x_rem_nxt  = div_rsp.rem;
    end
    if (state_r == BE_DIV_Y && div_rsp.done) begin
      y_quot_nxt = div_rsp.quot;
      y_rem_nxt  = div_rsp.rem;
    end
    if (state_r == BE_MUL) begin
      prod_nxt = PROD_W'(y_quot_r) * PROD_W'(cfg.src_width);
    end
    if (state_r == BE_INIT) begin
      // Row step lands on the next source row, minus the width walked across
      y_row_step_nxt = POS_W'(prod_r) - POS_W'(cfg.src_width);
      x_error_nxt    = '0;
      y_error_nxt    = '0;
      src_pos_nxt    = POS_W'(cfg.start_offset);
      dst_pos_nxt    = '0;
      col_left_nxt   = dw;
      row_left_nxt   = dh;
    end
    if (step_en) begin
      dst_pos_nxt = dst_pos_r + IDX_W'(1);
      if (row_end) begin
        src_pos_nxt  = pos_row;
        x_error_nxt  = '0;
        y_error_nxt  = y_err_wrap[DST_W-1:0];
        row_left_nxt = row_left_r - DST_W'(1);
        col_left_nxt = frame_end ? '0 : dw;
      end else begin
        src_pos_nxt  = pos_col;
        x_error_nxt  = x_err_wrap[DST_W-1:0];
        col_left_nxt = col_left_r - DST_W'(1);
      end
    end
  end

  // Result register
  always_comb begin
    out_valid_nxt  = out_valid_r && !out_ready;
    out_offset_nxt = out_offset_r;
    out_index_nxt  = out_index_r;
    out_rend_nxt   = out_rend_r;
    out_fend_nxt   = out_fend_r;
    if (step_en) begin
      out_valid_nxt  = 1'b1;
      out_offset_nxt = src_pos_r[OFFSET_BITS-1:0];
      out_index_nxt  = dst_pos_r;
      out_rend_nxt   = row_end;
      out_fend_nxt   = frame_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BE_IDLE;
      out_valid_r <= 1'b0;
      col_left_r  <= '0;
      row_left_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      col_left_r  <= col_left_nxt;
      row_left_r  <= row_left_nxt;
    end
    x_error_r    <= x_error_nxt;
    y_error_r    <= y_error_nxt;
    src_pos_r    <= src_pos_nxt;
    dst_pos_r    <= dst_pos_nxt;
    x_quot_r     <= x_quot_nxt;
    x_rem_r      <= x_rem_nxt;
    y_quot_r     <= y_quot_nxt;
    y_rem_r      <= y_rem_nxt;
    prod_r       <= prod_nxt;
    y_row_step_r <= y_row_step_nxt;
    out_offset_r <= out_offset_nxt;
    out_index_r  <= out_index_nxt;
    out_rend_r   <= out_rend_nxt;
    out_fend_r   <= out_fend_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_source_offset = out_offset_r;
  assign out_dest_index    = out_index_r;
  assign out_row_end       = out_rend_r;
  assign out_frame_end     = out_fend_r;

endmodule

[sv/bresenham_scaler_address_gen_unit.sv]
// Top level of the nearest-neighbor scaler address generator: config registers,
// front end, back end. Depends on bsag_pkg, bsag_front, bsag_back, assert_macros.svh.
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_ready    in_frame_start
//   out      output     out_valid / out_ready  out_source_offset, out_dest_index,
//                                              out_row_end, out_frame_end
//   cfg      input      psel/penable/pready    paddr, pwrite, pwdata, prdata
//
// An advancing word is stepped from the queue head once the result register is free;
// the result is registered onto out_valid, and the back end sustains one result per
// cycle while words are queued and out_ready holds. A frame restart steps only after
// setup: the divider start, the X and Y divisions, the multiply and the init state.
// rst_n is synchronous; after reset the first word always restarts the frame.
// A two-word queue lets the input side keep taking words while results stall, until full.
`include "assert_macros.svh"

module bresenham_scaler_address_gen_unit import bsag_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   in_frame_start,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [OFFSET_BITS-1:0] out_source_offset,
  output logic [IDX_W-1:0]       out_dest_index,
  output logic                   out_row_end,
  output logic                   out_frame_end,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [CFG_ADDR_W-1:0]  paddr,
  input  logic [CFG_DATA_W-1:0]  pwdata,
  output logic [CFG_DATA_W-1:0]  prdata,
  output logic                   pready
);

  cfg_t     cfg_r, cfg_nxt;
  cfg_reg_t reg_sel;
  logic     cfg_write;
  q_head_t  q_head;
  logic     q_pop;

  // Register file
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign reg_sel   = cfg_reg_t'(paddr[CFG_ADDR_W-1:2]);

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_write) begin
      unique case (reg_sel)
        REG_SRC_WIDTH:    cfg_nxt.src_width    = pwdata[SRC_W-1:0];
        REG_SRC_HEIGHT:   cfg_nxt.src_height   = pwdata[SRC_W-1:0];
        REG_DST_WIDTH:    cfg_nxt.dst_width    = pwdata[DST_W-1:0];
        REG_DST_HEIGHT:   cfg_nxt.dst_height   = pwdata[DST_W-1:0];
        REG_START_OFFSET: cfg_nxt.start_offset = pwdata[OFFSET_BITS-1:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.src_width    <= SRC_WIDTH_RST;
      cfg_r.src_height   <= SRC_HEIGHT_RST;
      cfg_r.dst_width    <= DST_WIDTH_RST;
      cfg_r.dst_height   <= DST_HEIGHT_RST;
      cfg_r.start_offset <= START_OFFSET_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Read-back
  always_comb begin
    unique case (reg_sel)
      REG_SRC_WIDTH:    prdata = CFG_DATA_W'(cfg_r.src_width);
      REG_SRC_HEIGHT:   prdata = CFG_DATA_W'(cfg_r.src_height);
      REG_DST_WIDTH:    prdata = CFG_DATA_W'(cfg_r.dst_width);
      REG_DST_HEIGHT:   prdata = CFG_DATA_W'(cfg_r.dst_height);
      REG_START_OFFSET: prdata = CFG_DATA_W'(cfg_r.start_offset);
      default:          prdata = '0;
    endcase
  end

  bsag_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_frame_start (in_frame_start),
    .q_pop          (q_pop),
    .q_head         (q_head)
  );

  bsag_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .q_head            (q_head),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_source_offset (out_source_offset),
    .out_dest_index    (out_dest_index),
    .out_row_end       (out_row_end),
    .out_frame_end     (out_frame_end)
  );

  // Checks
  `BSAG_ASSERT(a_full_has_head, !in_ready |-> q_head.valid, "queue full but head empty")
  `BSAG_ASSERT(a_pop_needs_head, q_pop |-> q_head.valid, "back end popped an empty queue")
  `BSAG_ASSERT(a_fend_is_rend, out_valid && out_frame_end |-> out_row_end, "frame end off row end")
  `BSAG_ASSERT_ALWAYS(a_reset_clears_out, !rst_n |=> !out_valid, "result valid after reset")

endmodule

[tb/sv/bresenham_scaler_address_gen_unit_tb.sv]
// Self-checking bench for the scaler address generator: directed and random pixel walks,
// checked word by word against an in-bench Bresenham predictor.
// Depends on bsag_pkg and bresenham_scaler_address_gen_unit.
module bresenham_scaler_address_gen_unit_tb import bsag_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 500000;
  localparam int SETTLE_CYCLES = 4;
  localparam int TAIL_CYCLES = 50;

  // One expected result word
  typedef struct packed {
    logic [OFFSET_BITS-1:0] src_off;
    logic [IDX_W-1:0]       dst_idx;
    logic                   row_end;
    logic                   frame_end;
  } pixel_addr_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic                   in_frame_start = 1'b0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [OFFSET_BITS-1:0] out_source_offset;
  logic [IDX_W-1:0]       out_dest_index;
  logic                   out_row_end;
  logic                   out_frame_end;
  logic                   psel = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0]  paddr = '0;
  logic [CFG_DATA_W-1:0]  pwdata = '0;
  logic [CFG_DATA_W-1:0]  prdata;
  logic                   pready;

  bresenham_scaler_address_gen_unit i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_frame_start    (in_frame_start),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_source_offset (out_source_offset),
    .out_dest_index    (out_dest_index),
    .out_row_end       (out_row_end),
    .out_frame_end     (out_frame_end),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  // Bench copy of the live registers
  logic [SRC_W-1:0]       cfg_src_w = SRC_WIDTH_RST;
  logic [SRC_W-1:0]       cfg_src_h = SRC_HEIGHT_RST;
  logic [DST_W-1:0]       cfg_dst_w = DST_WIDTH_RST;
  logic [DST_W-1:0]       cfg_dst_h = DST_HEIGHT_RST;
  logic [OFFSET_BITS-1:0] cfg_start = START_OFFSET_RST;

  // Predictor state: walk counters, accumulators, steps latched at frame start
  logic [DST_W-1:0]       px_left = '0;
  logic [DST_W-1:0]       rows_left = '0;
  logic [DST_W-1:0]       x_acc = '0;
  logic [DST_W-1:0]       y_acc = '0;
  logic [POS_W-1:0]       src_ptr = '0;
  logic [IDX_W-1:0]       dst_ptr = '0;
  logic [SRC_W-1:0]       step_x = '0;
  logic [SRC_W-1:0]       frac_x = '0;
  logic [IDX_W-1:0]       step_row = '0;
  logic [SRC_W-1:0]       frac_y = '0;

  pixel_addr_t pending_addrs[$];
  logic        start_flags[$];
  int          words_pushed = 0;
  int          words_issued = 0;
  int          words_taken = 0;
  int          mismatches = 0;
  int          rx_hold_left = 0;
  bit          idle_en = 1'b1;

  initial begin
    forever #1 clk = ~clk;
  end

  // Next pixel of the scaled walk; latches steps when a frame (re)starts
  function automatic pixel_addr_t scale_next_pixel(input logic restart);
    pixel_addr_t px;
    logic [31:0] dw, dh, acc;
    dw = (cfg_dst_w == 0) ? 32'd1 : 32'(cfg_dst_w);
    dh = (cfg_dst_h == 0) ? 32'd1 : 32'(cfg_dst_h);
    if (restart || rows_left == 0 || px_left == 0) begin
      step_x    = SRC_W'(32'(cfg_src_w) / dw);
      frac_x    = SRC_W'(32'(cfg_src_w) % dw);
      frac_y    = SRC_W'(32'(cfg_src_h) % dh);
      step_row  = IDX_W'((32'(cfg_src_h) / dh) * 32'(cfg_src_w) - 32'(cfg_src_w));
      x_acc     = '0;
      y_acc     = '0;
      src_ptr   = POS_W'(cfg_start);
      dst_ptr   = '0;
      px_left   = DST_W'(dw);
      rows_left = DST_W'(dh);
    end
    px.src_off   = src_ptr[OFFSET_BITS-1:0];
    px.dst_idx   = dst_ptr;
    px.row_end   = 1'b0;
    px.frame_end = 1'b0;
    dst_ptr = dst_ptr + IDX_W'(1);
    src_ptr = src_ptr + POS_W'(step_x);
    acc = 32'(x_acc) + 32'(frac_x);
    if (acc >= dw) begin
      acc = acc - dw;
      src_ptr = src_ptr + POS_W'(1);
    end
    x_acc = acc[DST_W-1:0];
    px_left = px_left - DST_W'(1);
    // row done: jump by the row step, plus one extra source row on carry
    if (px_left == 0) begin
      px.row_end = 1'b1;
      src_ptr = src_ptr + step_row[POS_W-1:0];
      acc = 32'(y_acc) + 32'(frac_y);
      if (acc >= dh) begin
        acc = acc - dh;
        src_ptr = src_ptr + POS_W'(cfg_src_w);
      end
      y_acc = acc[DST_W-1:0];
      x_acc = '0;
      rows_left = rows_left - DST_W'(1);
      if (rows_left == 0) begin
        px.frame_end = 1'b1;
      end else begin
        px_left = DST_W'(dw);
      end
    end
    return px;
  endfunction

  // Input driver: one word at a time from start_flags, random gaps between words while idle_en is set
  initial begin : word_driver
    int gap;
    gap = 0;
    forever begin
      @(posedge clk);
      if (in_valid && in_ready) begin
        pending_addrs.push_back(scale_next_pixel(in_frame_start));
        words_taken++;
      end
      if (!in_valid || in_ready) begin
        if (gap > 0) begin
          gap--;
          in_valid <= 1'b0;
        end else if (start_flags.size() > 0 && idle_en && $urandom_range(0, 7) == 0) begin
          gap = $urandom_range(1, 15) - 1;
          in_valid <= 1'b0;
        end else if (start_flags.size() > 0) begin
          in_valid <= 1'b1;
          in_frame_start <= start_flags.pop_front();
          words_issued++;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string fname, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s expected 0x%0h, got 0x%0h", $realtime, fname, want, got);
    end
  endtask

  // Result sink: checks each taken word, stalls in random bursts while idle_en is set or on a long hold
  initial begin : result_sink
    int gap;
    pixel_addr_t want;
    gap = 0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        if (pending_addrs.size() == 0) begin
          mismatches++;
          $display("%0t: expected no word, got offset 0x%0h index 0x%0h", $realtime,
                   out_source_offset, out_dest_index);
        end else begin
          want = pending_addrs.pop_front();
          check_field("source_offset", 32'(want.src_off), 32'(out_source_offset));
          check_field("dest_index", 32'(want.dst_idx), 32'(out_dest_index));
          check_field("row_end", 32'(want.row_end), 32'(out_row_end));
          check_field("frame_end", 32'(want.frame_end), 32'(out_frame_end));
        end
      end
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        out_ready <= 1'b0;
      end else if (gap > 0) begin
        gap--;
        out_ready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 7) == 0) begin
        gap = $urandom_range(1, 15) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog
  initial begin : watchdog
    int cycle_cnt;
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Queue one frame_start flag and return once the driver has put it on the bus
  task automatic send_word(input logic restart);
    int ticket;
    words_pushed++;
    ticket = words_pushed;
    start_flags.push_back(restart);
    wait (words_issued == ticket);
  endtask

  // Wait until every word is taken and every result has come back; ends on an edge
  task automatic drain_results();
    while (words_taken != words_pushed || pending_addrs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write: setup then access; next setup may follow on the same edge
  task automatic cfg_write(input cfg_reg_t reg_idx, input logic [CFG_DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (reg_idx)
      REG_SRC_WIDTH:    cfg_src_w = value[SRC_W-1:0];
      REG_SRC_HEIGHT:   cfg_src_h = value[SRC_W-1:0];
      REG_DST_WIDTH:    cfg_dst_w = value[DST_W-1:0];
      REG_DST_HEIGHT:   cfg_dst_h = value[DST_W-1:0];
      REG_START_OFFSET: cfg_start = value[OFFSET_BITS-1:0];
      default: ;
    endcase
  endtask

  // Write the registers picked by sel; call only with nothing in flight
  task automatic apply_config(input logic [SRC_W-1:0] sw, input logic [SRC_W-1:0] sh,
                              input logic [DST_W-1:0] dw, input logic [DST_W-1:0] dh,
                              input logic [OFFSET_BITS-1:0] so, input logic [4:0] sel);
    if (sel[REG_SRC_WIDTH])    cfg_write(REG_SRC_WIDTH, 32'(sw));
    if (sel[REG_SRC_HEIGHT])   cfg_write(REG_SRC_HEIGHT, 32'(sh));
    if (sel[REG_DST_WIDTH])    cfg_write(REG_DST_WIDTH, 32'(dw));
    if (sel[REG_DST_HEIGHT])   cfg_write(REG_DST_HEIGHT, 32'(dh));
    if (sel[REG_START_OFFSET]) cfg_write(REG_START_OFFSET, 32'(so));
    if (sel != 0) begin
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
    end
  endtask

  // Random geometry: mostly small frames so rows and frames end often
  task automatic pick_random_config(input bit all_regs);
    logic [SRC_W-1:0]       sw, sh;
    logic [DST_W-1:0]       dw, dh;
    logic [OFFSET_BITS-1:0] so;
    case ($urandom_range(0, 7))
      0, 1, 2, 3: begin
        sw = SRC_W'($urandom_range(1, 40));   sh = SRC_W'($urandom_range(1, 40));
        dw = DST_W'($urandom_range(1, 12));   dh = DST_W'($urandom_range(1, 6));
      end
      4, 5: begin
        sw = SRC_W'($urandom_range(0, 4095)); sh = SRC_W'($urandom_range(0, 4095));
        dw = DST_W'($urandom_range(0, 16));   dh = DST_W'($urandom_range(0, 8));
      end
      6: begin
        sw = SRC_W'($urandom_range(1, 8));    sh = SRC_W'($urandom_range(1, 8));
        dw = DST_W'($urandom_range(1, 40));   dh = DST_W'($urandom_range(1, 4));
      end
      default: begin
        sw = SRC_W'($urandom_range(0, 4095)); sh = SRC_W'($urandom_range(0, 4095));
        dw = DST_W'($urandom_range(0, 8191)); dh = DST_W'($urandom_range(0, 8191));
      end
    endcase
    so = $urandom_range(0, 1) ? OFFSET_BITS'($urandom_range(0, 22'h3FFFFF))
                              : OFFSET_BITS'(22'h3FFFFF - $urandom_range(0, 5000));
    apply_config(sw, sh, dw, dh, so, all_regs ? 5'h1F : 5'($urandom_range(0, 31)));
  endtask

  // After reset a plain advance word must still open a frame at the reset geometry
  task automatic test_reset_defaults();
    send_word(1'b0);
    send_word(1'b0);
    drain_results();
  endtask

  // Full 2x2 frame out of 5x3 with remainders, then a plain word after frame end
  task automatic test_frame_walk();
    apply_config(12'd5, 12'd3, 13'd2, 13'd2, 22'd7, 5'h1F);
    send_word(1'b1);
    repeat (4) send_word(1'b0);
    drain_results();
  endtask

  // Shrink the destination mid-frame: latched steps stay, live sizes take over
  task automatic test_live_resize();
    apply_config(12'd7, 12'd5, 13'd3, 13'd3, 22'd100, 5'h1F);
    send_word(1'b1);
    drain_results();
    apply_config(12'd0, 12'd0, 13'd2, 13'd2, 22'd0,
                 (5'b1 << REG_DST_WIDTH) | (5'b1 << REG_DST_HEIGHT));
    repeat (3) send_word(1'b0);
    drain_results();
  endtask

  // Top start offset with widest source: running offset wraps past the field
  task automatic test_offset_wrap();
    apply_config(12'd4095, 12'd1, 13'd2, 13'd1, 22'h3FFFFF, 5'h1F);
    send_word(1'b1);
    send_word(1'b0);
    drain_results();
  endtask

  // Zero destination sizes act as 1x1; zero source sizes are exercised too
  task automatic test_zero_dest();
    apply_config(12'd4095, 12'd4095, 13'd0, 13'd0, 22'h3FFFFF, 5'h1F);
    send_word(1'b0);
    send_word(1'b1);
    drain_results();
    apply_config(12'd0, 12'd0, 13'd0, 13'd0, 22'd0, 5'h1F);
    send_word(1'b1);
    drain_results();
  endtask

  // Largest upscale: one source pixel spread over 8191 columns
  task automatic test_upscale_extreme();
    apply_config(12'd1, 12'd1, 13'd8191, 13'd8191, 22'd0, 5'h1F);
    send_word(1'b1);
    repeat (3) send_word(1'b0);
    drain_results();
  endtask

  // Random phases; most are clean walks, some are noisy restarts
  task automatic test_random_frames(input int phases, input int words_per_phase);
    bit noisy;
    for (int p = 0; p < phases; p++) begin
      pick_random_config(p == 0);
      noisy = ($urandom_range(0, 4) == 0);
      for (int i = 0; i < words_per_phase; i++) begin
        if (noisy || i == 0) send_word(1'(($urandom_range(0, 1))));
        else send_word($urandom_range(0, 60) == 0);
      end
      drain_results();
    end
  endtask

  // Long result stall while words keep coming: the input side must back up
  task automatic test_output_stall();
    pick_random_config(1'b1);
    rx_hold_left = 300;
    send_word(1'b1);
    repeat (39) send_word($urandom_range(0, 30) == 0);
    drain_results();
  endtask

  // Sender stops until every result is back, then resumes sending
  task automatic test_sender_pause();
    pick_random_config(1'b1);
    repeat (20) send_word($urandom_range(0, 30) == 0);
    drain_results();
    repeat (20) send_word($urandom_range(0, 30) == 0);
    drain_results();
  endtask

  // Back-to-back words with no gaps on either side
  task automatic test_steady_stream();
    idle_en = 1'b0;
    pick_random_config(1'b1);
    send_word(1'b1);
    repeat (59) send_word($urandom_range(0, 60) == 0);
    drain_results();
  endtask

  initial begin : test_seq
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_frame_walk();
    test_live_resize();
    test_offset_wrap();
    test_zero_dest();
    test_upscale_extreme();
    test_random_frames(15, 60);
    test_output_stall();
    test_sender_pause();
    test_steady_stream();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_addrs.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
